[design/clg_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clg_pkg - shared types and constants of the liquid level gauge
// Widths, codes, lane control structs and the level table.
// ----------------------------------------------------------------------------
package clg_pkg;

    localparam int NUM_SENSORS = 10;
    localparam int RAW_W       = 16;
    localparam int BASE_W      = 32;
    localparam int DIG_W       = 4;
    localparam int NUM_DIGITS  = BASE_W / DIG_W;
    localparam int THR_W       = 16;
    localparam int THR_DIGITS  = THR_W / DIG_W;
    localparam int DIV_W       = 8;
    localparam int LEVEL_W     = 8;
    localparam int KIND_W      = 2;
    localparam int CNT_W       = 4;
    localparam int RUN_W       = 4;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 16;
    localparam int IN_DATA_W   = NUM_SENSORS * RAW_W;
    localparam int OUT_DATA_W  = 16;

    // register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SCAN_COUNT = 2'd1;

    localparam logic [THR_W-1:0] THRESHOLD_RESET  = 16'd100;
    localparam logic [DIV_W-1:0] SCAN_COUNT_RESET = 8'd10;

    typedef enum logic [KIND_W-1:0] {
        KIND_CLEAR = 2'd0,
        KIND_CAL   = 2'd1,
        KIND_MEAS  = 2'd2
    } t_kind;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_DIGIT,
        ST_FINISH
    } t_state;

    // control broadcast from the sequencer to every lane
    typedef struct packed {
        logic load;
        logic clear;
        logic div_step;
        logic dig_step;
        logic dig_first;
        logic dig_sub;
    } t_lane_ctl;

    // per-lane result of a measurement pass
    typedef struct packed {
        logic gt;
        logic nz;
    } t_lane_stat;

    // level for a run of covered sensors
    function automatic logic [LEVEL_W-1:0] level_of(input logic [RUN_W-1:0] run);
        logic [LEVEL_W-1:0] lv;
        case (run)
            4'd0:    lv = 8'd0;
            4'd1:    lv = 8'd26;
            4'd2:    lv = 8'd51;
            4'd3:    lv = 8'd77;
            4'd4:    lv = 8'd102;
            4'd5:    lv = 8'd128;
            4'd6:    lv = 8'd153;
            4'd7:    lv = 8'd179;
            4'd8:    lv = 8'd204;
            4'd9:    lv = 8'd230;
            default: lv = 8'd255;
        endcase
        return lv;
    endfunction

endpackage

[design/clg_lane.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clg_lane - one sensor lane
// Holds the sensor baseline in a rotating shift register, divides the raw
// count one quotient bit per cycle and adds or subtracts one digit per cycle.
// ----------------------------------------------------------------------------
module clg_lane (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  clg_pkg::t_lane_ctl        i_ctl,
    input  logic [clg_pkg::RAW_W-1:0] i_raw,
    input  logic [clg_pkg::DIV_W-1:0] i_div,
    input  logic [clg_pkg::DIG_W-1:0] i_thr_digit,
    output clg_pkg::t_lane_stat       o_stat
);
    import clg_pkg::*;

    logic [BASE_W-1:0] r_base,  n_base;
    logic [BASE_W-1:0] r_opnd,  n_opnd;
    logic [DIV_W-1:0]  r_rem,   n_rem;
    logic              r_carry, n_carry;
    logic              r_gt,    n_gt;
    logic              r_nz,    n_nz;

    logic [DIV_W:0]    rem_sh;
    logic [DIV_W+1:0]  rem_diff;
    logic              rem_ge;
    logic [DIG_W-1:0]  b_dig;
    logic [DIG_W-1:0]  o_dig;
    logic [DIG_W-1:0]  b_opd;
    logic              c_in;
    logic [DIG_W:0]    dsum;
    logic [DIG_W-1:0]  d_dig;
    logic              gt_in;
    logic              nz_in;

    // restoring division step on the low half of the operand
    always_comb begin
        rem_sh   = {r_rem, r_opnd[RAW_W-1]};
        rem_diff = {1'b0, rem_sh} - {2'b00, i_div};
        rem_ge   = ~rem_diff[DIV_W+1];
    end

    // digit adder: baseline plus operand, or operand minus baseline
    always_comb begin
        b_dig = r_base[DIG_W-1:0];
        o_dig = r_opnd[DIG_W-1:0];
        b_opd = i_ctl.dig_sub ? ~b_dig : b_dig;
        c_in  = i_ctl.dig_first ? i_ctl.dig_sub : r_carry;
        gt_in = i_ctl.dig_first ? 1'b0 : r_gt;
        nz_in = i_ctl.dig_first ? 1'b0 : r_nz;
        dsum  = {1'b0, o_dig} + {1'b0, b_opd} + {{DIG_W{1'b0}}, c_in};
        d_dig = dsum[DIG_W-1:0];
    end

    // next values of the lane registers
    always_comb begin
        n_base  = r_base;
        n_opnd  = r_opnd;
        n_rem   = r_rem;
        n_carry = r_carry;
        n_gt    = r_gt;
        n_nz    = r_nz;
        if (i_ctl.clear) begin
            n_base = '0;
        end
        if (i_ctl.load) begin
            n_opnd = {{(BASE_W-RAW_W){1'b0}}, i_raw};
            n_rem  = '0;
        end else if (i_ctl.div_step) begin
            n_rem                = rem_ge ? rem_diff[DIV_W-1:0] : rem_sh[DIV_W-1:0];
            n_opnd[RAW_W-1:0]    = {r_opnd[RAW_W-2:0], rem_ge};
        end else if (i_ctl.dig_step) begin
            n_opnd  = {{DIG_W{1'b0}}, r_opnd[BASE_W-1:DIG_W]};
            n_carry = dsum[DIG_W];
            if (i_ctl.dig_sub) begin
                // rotate the baseline unchanged, track the difference
                n_base = {b_dig, r_base[BASE_W-1:DIG_W]};
                n_nz   = nz_in | (d_dig != '0);
                if (d_dig > i_thr_digit) begin
                    n_gt = 1'b1;
                end else if (d_dig < i_thr_digit) begin
                    n_gt = 1'b0;
                end else begin
                    n_gt = gt_in;
                end
            end else begin
                n_base = {d_dig, r_base[BASE_W-1:DIG_W]};
            end
        end
    end

    // baseline resets to zero; working registers need none
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base <= '0;
        end else begin
            r_base <= n_base;
        end
    end

    always_ff @(posedge i_clk) begin
        r_opnd  <= n_opnd;
        r_rem   <= n_rem;
        r_carry <= n_carry;
        r_gt    <= n_gt;
        r_nz    <= n_nz;
    end

    assign o_stat.gt = r_gt;
    assign o_stat.nz = r_nz;

endmodule

[design/clg_seq.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clg_seq - item sequencer of the liquid level gauge
// Steps the lanes through division and digit passes and counts the cycles.
// ----------------------------------------------------------------------------
module clg_seq (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_accept,
    input  logic [clg_pkg::KIND_W-1:0] i_kind,
    input  logic                       i_raw_all_nz,
    input  logic                       i_out_free,
    output logic                       o_idle,
    output logic                       o_finish,
    output logic [clg_pkg::KIND_W-1:0] o_kind,
    output logic [clg_pkg::CNT_W-1:0]  o_cnt,
    output clg_pkg::t_lane_ctl         o_ctl
);
    import clg_pkg::*;

    t_state             r_state, n_state;
    logic [CNT_W-1:0]   r_cnt,   n_cnt;
    logic [KIND_W-1:0]  r_kind,  n_kind;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_accept) begin
                    if (i_kind == KIND_CAL) begin
                        n_state = i_raw_all_nz ? ST_DIV : ST_FINISH;
                    end else if (i_kind == KIND_MEAS) begin
                        n_state = ST_DIGIT;
                    end else begin
                        n_state = ST_FINISH;
                    end
                end
            end
            ST_DIV: begin
                if (r_cnt == CNT_W'(RAW_W - 1)) begin
                    n_state = ST_DIGIT;
                end
            end
            ST_DIGIT: begin
                if (r_cnt == CNT_W'(NUM_DIGITS - 1)) begin
                    n_state = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (i_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // step counter restarts at every state change; hold the item kind
    always_comb begin
        n_cnt  = (n_state != r_state) ? '0 : r_cnt + 1'b1;
        n_kind = i_accept ? i_kind : r_kind;
    end

    // outputs
    always_comb begin
        o_idle          = (r_state == ST_IDLE);
        o_finish        = (r_state == ST_FINISH);
        o_ctl.load      = i_accept;
        o_ctl.clear     = i_accept && (i_kind == KIND_CLEAR);
        o_ctl.div_step  = (r_state == ST_DIV);
        o_ctl.dig_step  = (r_state == ST_DIGIT);
        o_ctl.dig_first = (r_cnt == '0);
        o_ctl.dig_sub   = (r_kind == KIND_MEAS);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_kind <= n_kind;
    end

    assign o_kind = r_kind;
    assign o_cnt  = r_cnt;

endmodule

[design/capacitive_liquid_level_gauge.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// capacitive_liquid_level_gauge - top level
// Ten sensor lanes with serial dividers and 4-bit digit adders, driven by
// one sequencer; one result item for each scan item.
//
//   channel   direction  contents
//   s_axis    in         tdata raw_0..raw_9, tuser kind
//   m_axis    out        tdata level, all_nonzero
//   cfg       in         write enable, index, data (threshold, scan_count)
//
// A measure item runs 8 digit passes over the 32-bit baseline before the
// output register is loaded; a calibrate item first takes 16 quotient
// bits, and clear, unknown kinds and calibrate items with a zero raw count
// go straight to the output register. Input is ready again once the result
// is loaded. Reset is synchronous, active low, and zeroes the baselines.
// A new item is taken while a result waits; a full output register holds
// the sequencer in its last state.
module capacitive_liquid_level_gauge (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // raw_0 [15:0], raw_1 [31:16], ... raw_9 [159:144]
    input  logic [clg_pkg::IN_DATA_W-1:0]    s_axis_tdata,
    // kind [1:0]
    input  logic [clg_pkg::KIND_W-1:0]       s_axis_tuser,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // level [7:0], all_nonzero [8], zero [15:9]
    output logic [clg_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
    input  logic                             i_cfg_we,
    input  logic [clg_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [clg_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    import clg_pkg::*;

    logic [THR_W-1:0]       r_threshold;
    logic [DIV_W-1:0]       r_scan_count;
    logic                   r_all_nz;
    logic                   r_m_valid, n_m_valid;
    logic [OUT_DATA_W-1:0]  r_m_data;

    logic                   accept;
    logic                   raw_all_nz;
    logic                   seq_idle;
    logic                   seq_finish;
    logic [KIND_W-1:0]      seq_kind;
    logic [CNT_W-1:0]       seq_cnt;
    t_lane_ctl              lane_ctl;
    t_lane_stat             lane_stat [NUM_SENSORS];
    logic [DIV_W-1:0]       divisor;
    logic [DIG_W-1:0]       thr_digit;
    logic                   out_free;
    logic                   out_load;
    logic [RUN_W-1:0]       run;
    logic                   meas_nz;
    logic                   run_open;
    logic [LEVEL_W-1:0]     res_level;
    logic                   res_nz;

    assign s_axis_tready = seq_idle;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign out_free      = !r_m_valid || m_axis_tready;
    assign out_load      = seq_finish && out_free;

    // check every raw count of the incoming item for zero
    always_comb begin
        raw_all_nz = 1'b1;
        for (int i = 0; i < NUM_SENSORS; i++) begin
            if (s_axis_tdata[i*RAW_W +: RAW_W] == '0) begin
                raw_all_nz = 1'b0;
            end
        end
    end

    // a zero scan count divides by one
    assign divisor = (r_scan_count == '0) ? DIV_W'(1) : r_scan_count;

    // threshold digit for the current pass, zero above its top digit
    always_comb begin
        if (seq_cnt >= CNT_W'(THR_DIGITS)) begin
            thr_digit = '0;
        end else begin
            thr_digit = r_threshold[{seq_cnt[1:0], 2'b00} +: DIG_W];
        end
    end

    clg_seq u_seq (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (accept),
        .i_kind       (s_axis_tuser),
        .i_raw_all_nz (raw_all_nz),
        .i_out_free   (out_free),
        .o_idle       (seq_idle),
        .o_finish     (seq_finish),
        .o_kind       (seq_kind),
        .o_cnt        (seq_cnt),
        .o_ctl        (lane_ctl)
    );

    for (genvar g = 0; g < NUM_SENSORS; g++) begin : g_lane
        clg_lane u_lane (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_ctl       (lane_ctl),
            .i_raw       (s_axis_tdata[g*RAW_W +: RAW_W]),
            .i_div       (divisor),
            .i_thr_digit (thr_digit),
            .o_stat      (lane_stat[g])
        );
    end

    // count the unbroken run of covered sensors from the bottom
    always_comb begin
        run      = '0;
        run_open = 1'b1;
        meas_nz  = 1'b1;
        for (int i = 0; i < NUM_SENSORS; i++) begin
            run_open = run_open && lane_stat[i].gt;
            if (run_open) begin
                run = run + 1'b1;
            end
            if (!lane_stat[i].nz) begin
                meas_nz = 1'b0;
            end
        end
    end

    // form the result for the finished item
    always_comb begin
        res_level = '0;
        res_nz    = 1'b1;
        case (seq_kind)
            KIND_CAL: begin
                res_nz = r_all_nz;
            end
            KIND_MEAS: begin
                res_level = level_of(run);
                res_nz    = meas_nz;
            end
            default: begin
                res_nz = 1'b1;
            end
        endcase
    end

    always_comb begin
        n_m_valid = r_m_valid;
        if (out_load) begin
            n_m_valid = 1'b1;
        end else if (m_axis_tready) begin
            n_m_valid = 1'b0;
        end
    end

    // configuration registers and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold  <= THRESHOLD_RESET;
            r_scan_count <= SCAN_COUNT_RESET;
            r_m_valid    <= 1'b0;
        end else begin
            r_m_valid <= n_m_valid;
            if (i_cfg_we && (i_cfg_index == CFG_THRESHOLD)) begin
                r_threshold <= i_cfg_data[THR_W-1:0];
            end
            if (i_cfg_we && (i_cfg_index == CFG_SCAN_COUNT)) begin
                r_scan_count <= i_cfg_data[DIV_W-1:0];
            end
        end
    end

    // hold the zero check of the item and the output item
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_all_nz <= raw_all_nz;
        end
        if (out_load) begin
            r_m_data <= {{(OUT_DATA_W-LEVEL_W-1){1'b0}}, res_nz, res_level};
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_data;

endmodule
